// ===== rtl/core/cpi_pkg.sv =====
// Shared constants, stage payload types and the saturation helper for the circle intersection core.
package cpi_pkg;

  localparam int CoordW  = 32;
  localparam int RadiusW = 31;
  localparam int CountW  = 2;

  // Point count codes.
  localparam logic [CountW-1:0] CNT_NONE    = 2'd0;
  localparam logic [CountW-1:0] CNT_TANGENT = 2'd1;
  localparam logic [CountW-1:0] CNT_CROSS   = 2'd2;

  // Radicand widths of the two square roots and the divider shapes.
  localparam int DistSqW  = 64;
  localparam int HeightSqW = 62;
  localparam int FootDenW = 33;
  localparam int FootQuoW = 32;
  localparam int ProjDenW = 32;
  localparam int ProjQuoW = 31;
  localparam int ProjLanes = 4;

  // Carried alongside the centre distance square root.
  typedef struct packed {
    logic [CountW-1:0]         count;
    logic signed [CoordW-1:0]  x1;
    logic signed [CoordW-1:0]  y1;
    logic [RadiusW-1:0]        r1;
    logic                      dxs;
    logic                      dys;
    logic [31:0]               dxm;
    logic [31:0]               dym;
    logic                      ks;
    logic [64:0]               km;
    logic [61:0]               q1;
  } root1_side_t;

  // Carried alongside the foot distance division.
  typedef struct packed {
    logic [CountW-1:0]         count;
    logic signed [CoordW-1:0]  x1;
    logic signed [CoordW-1:0]  y1;
    logic [RadiusW-1:0]        r1;
    logic                      dxs;
    logic                      dys;
    logic [31:0]               dxm;
    logic [31:0]               dym;
    logic                      ks;
    logic                      ovf;
    logic [61:0]               q1;
    logic [31:0]               l;
  } quot_side_t;

  // Carried alongside the height square root.
  typedef struct packed {
    logic [CountW-1:0]         count;
    logic signed [CoordW-1:0]  x1;
    logic signed [CoordW-1:0]  y1;
    logic                      dxs;
    logic                      dys;
    logic [31:0]               dxm;
    logic [31:0]               dym;
    logic                      as;
    logic [31:0]               l;
    logic [62:0]               fxn;
    logic [62:0]               fyn;
  } root2_side_t;

  // Carried alongside the four projection divisions.
  typedef struct packed {
    logic [CountW-1:0]         count;
    logic signed [CoordW-1:0]  x1;
    logic signed [CoordW-1:0]  y1;
    logic                      dxs;
    logic                      dys;
    logic                      as;
  } proj_side_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [33:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/circle_pair_intersection.sv =====
// Top level of the circle pair intersection core: setup, square roots, divisions and point assembly.
//
//   channel  | signals                                       | beat
//   ---------+-----------------------------------------------+------------------------------
//   item     | item_valid/item_ready, first_*, second_*      | one circle pair
//   result   | result_valid/result_ready, point_count, pa_*, | count and up to two points
//            | pb_*                                          |
//
// One circle pair enters per cycle while the pipeline is not stalled; each pair passes through
// the 32 and 31 stage square roots and the 32 and 31 stage dividers in series.
// Reset clears only the valid bits of every stage; payload registers keep whatever they held.
// The whole pipeline moves as one: it advances whenever the output register is empty or its
// beat is taken, so a stall holds every stage in place.
module circle_pair_intersection (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic signed [cpi_pkg::CoordW-1:0]    first_x,
  input  logic signed [cpi_pkg::CoordW-1:0]    first_y,
  input  logic [cpi_pkg::RadiusW-1:0]          first_radius,
  input  logic signed [cpi_pkg::CoordW-1:0]    second_x,
  input  logic signed [cpi_pkg::CoordW-1:0]    second_y,
  input  logic [cpi_pkg::RadiusW-1:0]          second_radius,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [cpi_pkg::CountW-1:0]           point_count,
  output logic signed [cpi_pkg::CoordW-1:0]    pa_x,
  output logic signed [cpi_pkg::CoordW-1:0]    pa_y,
  output logic signed [cpi_pkg::CoordW-1:0]    pb_x,
  output logic signed [cpi_pkg::CoordW-1:0]    pb_y
);

  import cpi_pkg::*;

  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // Stage A: centre differences.
  logic                      a_v;
  logic signed [CoordW-1:0]  a_x1, a_y1;
  logic [RadiusW-1:0]        a_r1, a_r2;
  logic signed [32:0]        a_dx, a_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x1 <= first_x;
      a_y1 <= first_y;
      a_r1 <= first_radius;
      a_r2 <= second_radius;
      a_dx <= {second_x[CoordW-1], second_x} - {first_x[CoordW-1], first_x};
      a_dy <= {second_y[CoordW-1], second_y} - {first_y[CoordW-1], first_y};
    end
  end

  // Stage B: squares.
  logic                      b_v;
  logic signed [CoordW-1:0]  b_x1, b_y1;
  logic [RadiusW-1:0]        b_r1;
  logic                      b_dxs, b_dys;
  logic [31:0]               b_dxm, b_dym;
  logic [63:0]               b_dx2, b_dy2, b_s;
  logic [61:0]               b_q1, b_q2, b_m;

  logic [32:0]               dx_abs, dy_abs;
  logic [31:0]               rsum;
  logic [30:0]               rdiff;
  assign dx_abs = a_dx[32] ? -a_dx : a_dx;
  assign dy_abs = a_dy[32] ? -a_dy : a_dy;
  assign rsum   = {1'b0, a_r1} + {1'b0, a_r2};
  assign rdiff  = (a_r1 > a_r2) ? a_r1 - a_r2 : a_r2 - a_r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x1  <= a_x1;
      b_y1  <= a_y1;
      b_r1  <= a_r1;
      b_dxs <= a_dx[32];
      b_dys <= a_dy[32];
      b_dxm <= dx_abs[31:0];
      b_dym <= dy_abs[31:0];
      b_dx2 <= 64'(dx_abs[31:0]) * 64'(dx_abs[31:0]);
      b_dy2 <= 64'(dy_abs[31:0]) * 64'(dy_abs[31:0]);
      b_s   <= 64'(rsum) * 64'(rsum);
      b_q1  <= 62'(a_r1) * 62'(a_r1);
      b_q2  <= 62'(a_r2) * 62'(a_r2);
      b_m   <= 62'(rdiff) * 62'(rdiff);
    end
  end

  // Stage C: squared distance and classification.
  logic                      c_v;
  logic [CountW-1:0]         c_count;
  logic [63:0]               c_d;
  logic signed [CoordW-1:0]  c_x1, c_y1;
  logic [RadiusW-1:0]        c_r1;
  logic                      c_dxs, c_dys;
  logic [31:0]               c_dxm, c_dym;
  logic [61:0]               c_q1, c_q2;

  logic [64:0]               dsum;
  logic                      no_meet, touch;
  logic [CountW-1:0]         count_next;
  assign dsum    = {1'b0, b_dx2} + {1'b0, b_dy2};
  assign no_meet = dsum[64] || (dsum[63:0] > b_s) || (dsum == '0)
                   || (dsum[63:0] < {2'b00, b_m});
  assign touch   = (dsum[63:0] == b_s) || (dsum[63:0] == {2'b00, b_m});
  assign count_next = no_meet ? CNT_NONE : (touch ? CNT_TANGENT : CNT_CROSS);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_count <= count_next;
      c_d     <= dsum[63:0];
      c_x1    <= b_x1;
      c_y1    <= b_y1;
      c_r1    <= b_r1;
      c_dxs   <= b_dxs;
      c_dys   <= b_dys;
      c_dxm   <= b_dxm;
      c_dym   <= b_dym;
      c_q1    <= b_q1;
      c_q2    <= b_q2;
    end
  end

  // Stage D: numerator of the foot distance, then on into the distance square root.
  logic                      d_v;
  logic [DistSqW-1:0]        d_rad;
  root1_side_t               d_side;

  // The numerator is kept to 64 bits and read as a signed value, so very large pairs wrap.
  logic signed [63:0]        k_val;
  logic [64:0]               k_abs;
  assign k_val = $signed(64'(c_q1) + c_d - 64'(c_q2));
  assign k_abs = k_val[63] ? -{k_val[63], k_val} : {1'b0, k_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rad        <= c_d;
      d_side.count <= c_count;
      d_side.x1    <= c_x1;
      d_side.y1    <= c_y1;
      d_side.r1    <= c_r1;
      d_side.dxs   <= c_dxs;
      d_side.dys   <= c_dys;
      d_side.dxm   <= c_dxm;
      d_side.dym   <= c_dym;
      d_side.ks    <= k_val[63];
      d_side.km    <= k_abs;
      d_side.q1    <= c_q1;
    end
  end

  logic                      r1o_v;
  logic [DistSqW/2-1:0]      r1o_root;
  logic [$bits(root1_side_t)-1:0] r1o_bits;
  root1_side_t               r1o_side;

  cpi_sqrt #(
    .W  (DistSqW),
    .SW ($bits(root1_side_t))
  ) u_dist_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_v),
    .in_rad    (d_rad),
    .in_side   (d_side),
    .out_valid (r1o_v),
    .out_root  (r1o_root),
    .out_side  (r1o_bits)
  );
  assign r1o_side = r1o_bits;

  // Stage E: divider set-up for a = K / 2l; a quotient beyond 32 bits is clamped to r1 anyway.
  logic                      e_v;
  logic [FootDenW-1:0]       e_hi;
  logic [FootQuoW-1:0]       e_lo;
  logic [FootDenW-1:0]       e_den;
  quot_side_t                e_side;

  logic [FootDenW-1:0]       den2l;
  logic [FootDenW-1:0]       k_hi;
  logic                      k_ovf;
  assign den2l = {r1o_root, 1'b0};
  assign k_hi  = r1o_side.km[64:32];
  assign k_ovf = k_hi >= den2l;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= r1o_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_hi         <= k_ovf ? '0 : k_hi;
      e_lo         <= r1o_side.km[31:0];
      e_den        <= den2l;
      e_side.count <= r1o_side.count;
      e_side.x1    <= r1o_side.x1;
      e_side.y1    <= r1o_side.y1;
      e_side.r1    <= r1o_side.r1;
      e_side.dxs   <= r1o_side.dxs;
      e_side.dys   <= r1o_side.dys;
      e_side.dxm   <= r1o_side.dxm;
      e_side.dym   <= r1o_side.dym;
      e_side.ks    <= r1o_side.ks;
      e_side.ovf   <= k_ovf;
      e_side.q1    <= r1o_side.q1;
      e_side.l     <= r1o_root;
    end
  end

  logic                          q1o_v;
  logic [0:0][FootQuoW-1:0]      q1o_quo;
  logic [$bits(quot_side_t)-1:0] q1o_bits;
  quot_side_t                    q1o_side;

  cpi_div #(
    .DW    (FootDenW),
    .QW    (FootQuoW),
    .LANES (1),
    .SW    ($bits(quot_side_t))
  ) u_foot_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_v),
    .in_hi     (e_hi),
    .in_lo     (e_lo),
    .in_den    (e_den),
    .in_side   (e_side),
    .out_valid (q1o_v),
    .out_quo   (q1o_quo),
    .out_side  (q1o_bits)
  );
  assign q1o_side = q1o_bits;

  // Stage F: clamp a to the first radius.
  logic                      f_v;
  logic [RadiusW-1:0]        f_amag;
  quot_side_t                f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= q1o_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_amag <= (q1o_side.ovf || (q1o_quo[0] > {1'b0, q1o_side.r1}))
                ? q1o_side.r1 : q1o_quo[0][RadiusW-1:0];
      f_side <= q1o_side;
    end
  end

  // Stage G: a squared and the foot projection numerators.
  logic                      g_v;
  logic [61:0]               g_asq;
  logic [62:0]               g_fxn, g_fyn;
  quot_side_t                g_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_asq  <= 62'(f_amag) * 62'(f_amag);
      g_fxn  <= 63'(f_amag) * 63'(f_side.dxm);
      g_fyn  <= 63'(f_amag) * 63'(f_side.dym);
      g_side <= f_side;
    end
  end

  // Stage H: radicand of the height.
  logic                      h_v;
  logic [HeightSqW-1:0]      h_rad;
  root2_side_t               h_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_rad        <= g_side.q1 - g_asq;
      h_side.count <= g_side.count;
      h_side.x1    <= g_side.x1;
      h_side.y1    <= g_side.y1;
      h_side.dxs   <= g_side.dxs;
      h_side.dys   <= g_side.dys;
      h_side.dxm   <= g_side.dxm;
      h_side.dym   <= g_side.dym;
      h_side.as    <= g_side.ks;
      h_side.l     <= g_side.l;
      h_side.fxn   <= g_fxn;
      h_side.fyn   <= g_fyn;
    end
  end

  logic                           r2o_v;
  logic [HeightSqW/2-1:0]         r2o_root;
  logic [$bits(root2_side_t)-1:0] r2o_bits;
  root2_side_t                    r2o_side;

  cpi_sqrt #(
    .W  (HeightSqW),
    .SW ($bits(root2_side_t))
  ) u_height_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_v),
    .in_rad    (h_rad),
    .in_side   (h_side),
    .out_valid (r2o_v),
    .out_root  (r2o_root),
    .out_side  (r2o_bits)
  );
  assign r2o_side = r2o_bits;

  // Stage I: perpendicular numerators; every projection is at most r1, so the quotient fits 31 bits.
  // Lanes: foot x, foot y, height x, height y.
  logic                               i_v;
  logic [ProjLanes-1:0][ProjDenW-1:0] i_hi;
  logic [ProjLanes-1:0][ProjQuoW-1:0] i_lo;
  logic [ProjDenW-1:0]                i_den;
  proj_side_t                         i_side;

  logic [62:0]               hxn, hyn;
  assign hxn = 63'(r2o_root) * 63'(r2o_side.dxm);
  assign hyn = 63'(r2o_root) * 63'(r2o_side.dym);

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (en) begin
      i_v <= r2o_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_hi[0]      <= r2o_side.fxn[62:31];
      i_lo[0]      <= r2o_side.fxn[30:0];
      i_hi[1]      <= r2o_side.fyn[62:31];
      i_lo[1]      <= r2o_side.fyn[30:0];
      i_hi[2]      <= hxn[62:31];
      i_lo[2]      <= hxn[30:0];
      i_hi[3]      <= hyn[62:31];
      i_lo[3]      <= hyn[30:0];
      i_den        <= r2o_side.l;
      i_side.count <= r2o_side.count;
      i_side.x1    <= r2o_side.x1;
      i_side.y1    <= r2o_side.y1;
      i_side.dxs   <= r2o_side.dxs;
      i_side.dys   <= r2o_side.dys;
      i_side.as    <= r2o_side.as;
    end
  end

  logic                               q2o_v;
  logic [ProjLanes-1:0][ProjQuoW-1:0] q2o_quo;
  logic [$bits(proj_side_t)-1:0]      q2o_bits;
  proj_side_t                         q2o_side;

  cpi_div #(
    .DW    (ProjDenW),
    .QW    (ProjQuoW),
    .LANES (ProjLanes),
    .SW    ($bits(proj_side_t))
  ) u_proj_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (i_v),
    .in_hi     (i_hi),
    .in_lo     (i_lo),
    .in_den    (i_den),
    .in_side   (i_side),
    .out_valid (q2o_v),
    .out_quo   (q2o_quo),
    .out_side  (q2o_bits)
  );
  assign q2o_side = q2o_bits;

  // Output stage: signs back on, sums, saturation and selection by count.
  logic signed [33:0]        fx, fy, hx, hy;
  logic signed [33:0]        x1w, y1w;
  logic signed [CoordW-1:0]  pax_n, pay_n, pbx_n, pby_n;

  assign fx  = (q2o_side.as ^ q2o_side.dxs) ? -$signed({3'b000, q2o_quo[0]})
                                            :  $signed({3'b000, q2o_quo[0]});
  assign fy  = (q2o_side.as ^ q2o_side.dys) ? -$signed({3'b000, q2o_quo[1]})
                                            :  $signed({3'b000, q2o_quo[1]});
  assign hx  = q2o_side.dxs ? -$signed({3'b000, q2o_quo[2]}) : $signed({3'b000, q2o_quo[2]});
  assign hy  = q2o_side.dys ? -$signed({3'b000, q2o_quo[3]}) : $signed({3'b000, q2o_quo[3]});
  assign x1w = {{2{q2o_side.x1[CoordW-1]}}, q2o_side.x1};
  assign y1w = {{2{q2o_side.y1[CoordW-1]}}, q2o_side.y1};

  always_comb begin
    pax_n = '0;
    pay_n = '0;
    pbx_n = '0;
    pby_n = '0;
    case (q2o_side.count)
      CNT_TANGENT: begin
        pax_n = sat32(x1w + fx);
        pay_n = sat32(y1w + fy);
      end
      CNT_CROSS: begin
        pax_n = sat32(x1w + fx - hy);
        pay_n = sat32(y1w + fy + hx);
        pbx_n = sat32(x1w + fx + hy);
        pby_n = sat32(y1w + fy - hx);
      end
      default: begin
        pax_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= q2o_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point_count <= q2o_side.count;
      pa_x        <= pax_n;
      pa_y        <= pay_n;
      pb_x        <= pbx_n;
      pb_y        <= pby_n;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (point_count == CNT_NONE || point_count == CNT_TANGENT
                      || point_count == CNT_CROSS))
    else $error("point count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && point_count == CNT_NONE)
      |-> (pa_x == '0 && pa_y == '0 && pb_x == '0 && pb_y == '0))
    else $error("points not cleared when circles do not meet");

  a_tangent_pb: assert property (@(posedge clk) disable iff (rst)
    (result_valid && point_count == CNT_TANGENT) |-> (pb_x == '0 && pb_y == '0))
    else $error("second point not cleared for a tangent pair");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result beat present straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(pa_x) && $stable(pb_y)))
    else $error("stalled result changed");

endmodule

// ===== rtl/core/cpi_sqrt.sv =====
// Pipelined bit-by-bit integer square root, one result bit per register stage.
module cpi_sqrt #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     in_rad,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [W/2-1:0]   out_root,
  output logic [SW-1:0]    out_side
);

  localparam int N = W / 2;

  logic          val_q  [1:N];
  logic [W-1:0]  v_q    [1:N];
  logic [W-1:0]  r_q    [1:N];
  logic [SW-1:0] side_q [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [W:0] Bit = {{W{1'b0}}, 1'b1} << (W - 2 - 2 * i);
    logic          cur_val;
    logic [W-1:0]  cur_v;
    logic [W-1:0]  cur_r;
    logic [SW-1:0] cur_side;
    logic [W:0]    trial;
    logic          take;

    if (i == 0) begin : g_first
      assign cur_val  = in_valid;
      assign cur_v    = in_rad;
      assign cur_r    = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_val  = val_q[i];
      assign cur_v    = v_q[i];
      assign cur_r    = r_q[i];
      assign cur_side = side_q[i];
    end

    assign trial = {1'b0, cur_r} + Bit;
    assign take  = {1'b0, cur_v} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[i+1] <= 1'b0;
      end else if (en) begin
        val_q[i+1] <= cur_val;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[i+1]    <= take ? cur_v - trial[W-1:0] : cur_v;
        r_q[i+1]    <= take ? (cur_r >> 1) + Bit[W-1:0] : cur_r >> 1;
        side_q[i+1] <= cur_side;
      end
    end
  end

  assign out_valid = val_q[N];
  assign out_root  = r_q[N][N-1:0];
  assign out_side  = side_q[N];

endmodule

// ===== rtl/core/cpi_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, lanes share one divisor.
module cpi_div #(
  parameter int DW    = 33,
  parameter int QW    = 32,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][DW-1:0]    in_hi,
  input  logic [LANES-1:0][QW-1:0]    in_lo,
  input  logic [DW-1:0]               in_den,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    out_quo,
  output logic [SW-1:0]               out_side
);

  logic                     val_q  [1:QW];
  logic [LANES-1:0][DW-1:0] rem_q  [1:QW];
  logic [LANES-1:0][QW-1:0] lq_q   [1:QW];
  logic [DW-1:0]            den_q  [1:QW];
  logic [SW-1:0]            side_q [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic                     cur_val;
    logic [LANES-1:0][DW-1:0] cur_rem;
    logic [LANES-1:0][QW-1:0] cur_lq;
    logic [DW-1:0]            cur_den;
    logic [SW-1:0]            cur_side;
    logic [LANES-1:0][DW-1:0] nxt_rem;
    logic [LANES-1:0][QW-1:0] nxt_lq;

    if (i == 0) begin : g_first
      assign cur_val  = in_valid;
      assign cur_rem  = in_hi;
      assign cur_lq   = in_lo;
      assign cur_den  = in_den;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_val  = val_q[i];
      assign cur_rem  = rem_q[i];
      assign cur_lq   = lq_q[i];
      assign cur_den  = den_q[i];
      assign cur_side = side_q[i];
    end

    // The dividend's low bits leave at the top while quotient bits enter at the bottom.
    for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [DW:0] t;
      logic        ge;
      logic [DW:0] diff;
      assign t    = {cur_rem[j], cur_lq[j][QW-1]};
      assign ge   = t >= {1'b0, cur_den};
      assign diff = t - {1'b0, cur_den};
      assign nxt_rem[j] = ge ? diff[DW-1:0] : t[DW-1:0];
      assign nxt_lq[j]  = {cur_lq[j][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[i+1] <= 1'b0;
      end else if (en) begin
        val_q[i+1] <= cur_val;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1]  <= nxt_rem;
        lq_q[i+1]   <= nxt_lq;
        den_q[i+1]  <= cur_den;
        side_q[i+1] <= cur_side;
      end
    end
  end

  assign out_valid = val_q[QW];
  assign out_quo   = lq_q[QW];
  assign out_side  = side_q[QW];

endmodule

// ===== sim/tb_circle_pair_intersection.sv =====
// Self-checking testbench for the circle pair intersection core.
`timescale 1ns / 1ps

class intersection_board;
  typedef struct packed {
    logic [1:0]         count;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } points_t;

  points_t pending[$];
  int      mismatches;

  function new();
    mismatches = 0;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function logic signed [31:0] clamp32(longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  static function points_t solve_pair(logic signed [31:0] x1, logic signed [31:0] y1,
                                      logic [30:0] r1, logic signed [31:0] x2,
                                      logic signed [31:0] y2, logic [30:0] r2);
    points_t         p;
    longint          dx, dy, l, k, a, h, fx, fy, hx, hy, ll;
    longint unsigned mdx, mdy, dd, s, m, q1, q2, ma;
    logic [64:0]     dsum;
    p = '0;
    dx = longint'(x2) - longint'(x1);
    dy = longint'(y2) - longint'(y1);
    mdx = dx < 0 ? -dx : dx;
    mdy = dy < 0 ? -dy : dy;
    dsum = {1'b0, mdx * mdx} + {1'b0, mdy * mdy};
    dd = dsum[63:0];
    s = (longint'(r1) + longint'(r2)) * (longint'(r1) + longint'(r2));
    m = r1 > r2 ? longint'(r1 - r2) : longint'(r2 - r1);
    m = m * m;
    if (dsum[64] || dd > s || dd == 0 || dd < m) return p;
    p.count = (dd == s || dd == m) ? cpi_pkg::CNT_TANGENT : cpi_pkg::CNT_CROSS;
    l = int_sqrt(dd);
    q1 = longint'(r1) * longint'(r1);
    q2 = longint'(r2) * longint'(r2);
    if (q1 + dd >= q2) k = q1 + dd - q2;
    else k = -longint'(q2 - q1 - dd);
    ll = 2 * l;
    a = k / ll;
    if (a > longint'(r1)) a = r1;
    if (a < -longint'(r1)) a = -longint'(r1);
    ma = a < 0 ? -a : a;
    h = int_sqrt(q1 - ma * ma);
    fx = (a * dx) / l;
    fy = (a * dy) / l;
    hx = (h * dx) / l;
    hy = (h * dy) / l;
    if (p.count == cpi_pkg::CNT_TANGENT) begin
      p.ax = clamp32(x1 + fx);
      p.ay = clamp32(y1 + fy);
    end else begin
      p.ax = clamp32(x1 + fx - hy);
      p.ay = clamp32(y1 + fy + hx);
      p.bx = clamp32(x1 + fx + hy);
      p.by = clamp32(y1 + fy - hx);
    end
    return p;
  endfunction

  function void note_pair(logic signed [31:0] x1, logic signed [31:0] y1, logic [30:0] r1,
                          logic signed [31:0] x2, logic signed [31:0] y2, logic [30:0] r2);
    pending.push_back(solve_pair(x1, y1, r1, x2, y2, r2));
  endfunction

  function void check_points(points_t got);
    points_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result beat: %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected count %0d a(%0d,%0d) b(%0d,%0d),",
                  " got %0d a(%0d,%0d) b(%0d,%0d)"},
                 want.count, want.ax, want.ay, want.bx, want.by,
                 got.count, got.ax, got.ay, got.bx, got.by);
    end
  endfunction
endclass

module tb_circle_pair_intersection;
  import cpi_pkg::*;

  localparam int Latency = 136;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic signed [CoordW-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic [RadiusW-1:0] first_radius = '0, second_radius = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [CountW-1:0] point_count;
  logic signed [CoordW-1:0] pa_x, pa_y, pb_x, pb_y;

  intersection_board board = new();
  longint cycles = 0;
  bit     hold_off = 1'b0;
  bit     sending_done = 1'b0;

  circle_pair_intersection dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic int pick_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 55) return 0;
    if (g < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // One circle pair beat; the valid stays up when the next pair follows at once.
  task automatic offer_pair(logic signed [31:0] x1, logic signed [31:0] y1, logic [30:0] r1,
                            logic signed [31:0] x2, logic signed [31:0] y2, logic [30:0] r2,
                            int gap);
    first_x <= x1; first_y <= y1; first_radius <= r1;
    second_x <= x2; second_y <= y2; second_radius <= r2;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    board.note_pair(x1, y1, r1, x2, y2, r2);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_pair(int gap);
    logic signed [31:0] x1, y1, x2, y2;
    logic [30:0] r1, r2;
    int shape, scale;
    longint ang;
    shape = $urandom_range(0, 9);
    scale = $urandom_range(4, 30);
    x1 = $urandom; y1 = $urandom;
    if (shape < 7) begin
      // Centres close enough that the circles usually cross or nest.
      x1 = $signed(x1) >>> (31 - scale);
      y1 = $signed(y1) >>> (31 - scale);
      x2 = x1 + ($signed(32'($urandom)) >>> (32 - scale));
      y2 = y1 + ($signed(32'($urandom)) >>> (32 - scale));
      r1 = 31'($urandom) >> (31 - scale);
      r2 = 31'($urandom) >> (31 - scale);
    end else if (shape == 7) begin
      // Tangent from outside along an axis.
      r1 = 31'($urandom) >> (31 - scale);
      r2 = 31'($urandom) >> (31 - scale);
      x1 = $signed(x1) >>> 2; y1 = $signed(y1) >>> 2;
      ang = $urandom_range(0, 1);
      x2 = ang ? x1 + (r1 + r2) : x1;
      y2 = ang ? y1 : y1 - (r1 + r2);
    end else if (shape == 8) begin
      // Tangent from inside.
      r1 = 31'($urandom) >> (31 - scale);
      r2 = 31'($urandom) >> (31 - scale);
      x1 = $signed(x1) >>> 2; y1 = $signed(y1) >>> 2;
      x2 = x1 - (r1 > r2 ? r1 - r2 : r2 - r1);
      y2 = y1;
    end else begin
      x2 = $urandom; y2 = $urandom;
      r1 = 31'($urandom); r2 = 31'($urandom);
    end
    offer_pair(x1, y1, r1, x2, y2, r2, gap);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Apart, coincident, nested, tangent outside and inside, crossing, zero radii.
    offer_pair(0, 0, 31'h10000, 32'h50000, 0, 31'h10000, 0);
    offer_pair(32'h1234, -32'sh5678, 31'h20000, 32'h1234, -32'sh5678, 31'h20000, 0);
    offer_pair(0, 0, 31'h10000, 0, 0, 31'h30000, 1);
    offer_pair(0, 0, 31'h100000, 32'h10000, 0, 31'h10000, 0);
    offer_pair(0, 0, 31'h10000, 32'h20000, 0, 31'h10000, 0);
    offer_pair(0, 0, 31'h30000, 0, 32'h10000, 31'h20000, 0);
    offer_pair(0, 0, 31'h20000, 32'h10000, 32'h10000, 31'h20000, 2);
    offer_pair(5, 7, 31'd0, 9, 7, 31'd0, 0);
    offer_pair(5, 7, 31'd0, 5, 7, 31'd0, 0);
    offer_pair(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0);
    offer_pair(32'sh8000_0000, 0, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF, 0);
    offer_pair(32'sh7FFF_0000, 32'sh7FFF_0000, 31'h7FFF_FFFF,
               32'sh7FFE_0000, 32'sh7FFF_0000, 31'h7FFF_FFFF, 0);
    offer_pair(32'sh8000_0000, 32'sh8000_0000, 31'h4000_0000,
               32'sh8000_0000, 32'sh8001_0000, 31'h4000_0000, 0);
    offer_pair(32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1, 31'h7FFF_FFFF, 0);
    offer_pair(-32'sh30000, 32'sh40000, 31'h50000, 32'sh30000, -32'sh40000, 31'h50000, 3);
    offer_pair(0, 0, 31'h7FFF_FFFF, 32'sh10000, 0, 31'h7FFF_FFFF, 0);
    offer_pair(0, 0, 31'd1, 1, 1, 31'd1, 0);
    for (int i = 0; i < 585; i++) begin
      // One long receiver hold-off while pairs keep arriving back to back.
      if (i == 200) hold_off = 1'b1;
      random_pair((i >= 200 && i < 400) ? 0 : pick_gap());
    end
    item_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    @(negedge rst);
    wait (hold_off);
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // Receiver: random stalls, with stretches of constant readiness.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result_valid && result_ready)
        board.check_points('{point_count, pa_x, pa_y, pb_x, pb_y});
      if (hold_off) stall = 1;
      else if (cycles % 4000 < 1500) stall = 0;
      else stall = pick_gap();
      result_ready <= (stall == 0);
    end
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0 && cycles < CycleLimit) @(posedge clk);
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      repeat (Latency + 20) @(posedge clk);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/cpi_pkg.sv
rtl/core/cpi_sqrt.sv
rtl/core/cpi_div.sv
rtl/core/circle_pair_intersection.sv
sim/tb_circle_pair_intersection.sv
